// File: rtl/expression_lexer_implicit_mul_unit_defines.svh
// Assertion macros shared by the tokenizer modules.
`ifndef EXPRESSION_LEXER_IMPLICIT_MUL_UNIT_DEFINES_SVH
`define EXPRESSION_LEXER_IMPLICIT_MUL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define ELEXM_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ELEXM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ELEXM_ASSERT(label, ante, cons, msg)
`define ELEXM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: rtl/elexm_pkg.sv
package elexm_pkg;

  localparam int MANT_W      = 64;
  localparam int FRAC_W      = 5;
  localparam int CNT_W       = 5;
  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    KIND_CONST = 3'd0,
    KIND_VAR   = 3'd1,
    KIND_OP    = 3'd2,
    KIND_ERR   = 3'd3,
    KIND_END   = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PREV_NONE  = 3'd0,
    PREV_CONST = 3'd1,
    PREV_VAR   = 3'd2,
    PREV_CLOSE = 3'd3,
    PREV_OP    = 3'd4
  } prev_t;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] symbol;
  } slot_t;

  // All results caused by one request. At most one of them is a constant,
  // so the mantissa and fraction count are shared by the slots.
  typedef struct packed {
    logic [1:0]        count;
    slot_t [2:0]       slots;
    logic [MANT_W-1:0] mantissa;
    logic [FRAC_W-1:0] frac;
    logic              eoe;
  } bundle_t;

endpackage

// File: rtl/expression_lexer_implicit_mul_unit.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready   | in_char_code, in_is_last
// out     | output    | out_valid / out_ready | out_token_kind, out_symbol, out_mantissa,
//         |           |                       | out_fraction_digits, out_last_of_run,
//         |           |                       | out_end_of_expression
//
// A request is classified in the cycle it is accepted, and its results are queued as one entry.
// The back end drives one result per cycle while out_ready is high, fed by a two-entry queue.
// Unstalled, requests with at most one result sustain one per cycle; the queue absorbs bursts.
// Reset is synchronous and active low; the block is ready in the first cycle after reset.
// A stalled output only holds the input once the queue has filled.

module expression_lexer_implicit_mul_unit import elexm_pkg::*; #(
  parameter int MAX_DIGITS = 19
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_char_code,
  input  logic              in_is_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_token_kind,
  output logic [7:0]        out_symbol,
  output logic [MANT_W-1:0] out_mantissa,
  output logic [FRAC_W-1:0] out_fraction_digits,
  output logic              out_last_of_run,
  output logic              out_end_of_expression
);

  logic    q_full, q_push, q_empty, q_pop;
  bundle_t q_wdata, q_rdata;

  elexm_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .in_is_last   (in_is_last),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  elexm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  elexm_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (q_empty),
    .q_data                (q_rdata),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_token_kind        (out_token_kind),
    .out_symbol            (out_symbol),
    .out_mantissa          (out_mantissa),
    .out_fraction_digits   (out_fraction_digits),
    .out_last_of_run       (out_last_of_run),
    .out_end_of_expression (out_end_of_expression)
  );

endmodule

// File: rtl/elexm_front.sv
`include "expression_lexer_implicit_mul_unit_defines.svh"

module elexm_front import elexm_pkg::*; #(
  parameter int MAX_DIGITS = 19
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_is_last,
  input  logic       q_full,
  output logic       q_push,
  output bundle_t    q_data
);

  localparam logic [CNT_W-1:0] MAX_D  = CNT_W'(MAX_DIGITS);
  localparam logic [CNT_W-1:0] MAX_D1 = CNT_W'(MAX_DIGITS + 1);

  logic              in_num_r, in_num_nxt;
  logic [MANT_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic [FRAC_W-1:0] fcnt_r, fcnt_nxt;
  logic              pt_r, pt_nxt;
  logic              pt2_r, pt2_nxt;
  prev_t             prev_r, prev_nxt;
  logic              disc_r, disc_nxt;

  logic              is_digit, is_alpha, is_space, is_oper;
  logic [MANT_W-1:0] val_mul10;
  bundle_t           bnd;
  logic              err, consumed;

  assign is_digit = (in_char_code >= CH_ZERO) && (in_char_code <= CH_NINE);
  assign is_alpha = ((in_char_code >= CH_UC_A) && (in_char_code <= CH_UC_Z)) ||
                    ((in_char_code >= CH_LC_A) && (in_char_code <= CH_LC_Z));
  assign is_space = (in_char_code == CH_SPACE) ||
                    ((in_char_code >= CH_TAB) && (in_char_code <= CH_CR));
  assign is_oper  = (in_char_code == CH_PLUS) || (in_char_code == CH_MINUS) ||
                    (in_char_code == CH_STAR) || (in_char_code == CH_SLASH) ||
                    (in_char_code == CH_CARET) || (in_char_code == CH_OPEN) ||
                    (in_char_code == CH_CLOSE);

  assign val_mul10 = (val_r << 3) + (val_r << 1) + {{(MANT_W-4){1'b0}}, in_char_code[3:0]};

  always_comb begin
    in_num_nxt = in_num_r;
    val_nxt    = val_r;
    dcnt_nxt   = dcnt_r;
    fcnt_nxt   = fcnt_r;
    pt_nxt     = pt_r;
    pt2_nxt    = pt2_r;
    prev_nxt   = prev_r;
    disc_nxt   = disc_r;
    bnd        = '0;
    err        = 1'b0;
    consumed   = 1'b0;

    if (disc_r) begin
      if (in_is_last) begin
        disc_nxt = 1'b0;
      end
    end else begin
      if (in_num_r) begin
        if (is_digit) begin
          if (dcnt_r < MAX_D) begin
            val_nxt  = val_mul10;
            dcnt_nxt = dcnt_r + CNT_W'(1);
            if (pt_r) begin
              fcnt_nxt = fcnt_r + FRAC_W'(1);
            end
          end else begin
            dcnt_nxt = MAX_D1;
          end
          consumed = 1'b1;
        end else if (in_char_code == CH_POINT) begin
          if (pt_r) begin
            pt2_nxt = 1'b1;
          end else begin
            pt_nxt = 1'b1;
          end
          consumed = 1'b1;
        end else begin
          if (!pt2_r && (dcnt_r <= MAX_D)) begin
            bnd.slots[bnd.count] = '{kind: KIND_CONST, symbol: 8'd0};
            bnd.mantissa = val_r;
            bnd.frac     = fcnt_r;
            prev_nxt     = PREV_CONST;
          end else begin
            bnd.slots[bnd.count] = '{kind: KIND_ERR, symbol: 8'd0};
            err      = 1'b1;
            consumed = 1'b1;
          end
          bnd.count  = bnd.count + 2'd1;
          in_num_nxt = 1'b0;
          val_nxt    = '0;
          dcnt_nxt   = '0;
          fcnt_nxt   = '0;
          pt_nxt     = 1'b0;
          pt2_nxt    = 1'b0;
        end
      end

      if (!consumed) begin
        if (is_space) begin
          // Whitespace only separates tokens.
        end else if (is_digit || is_alpha || (in_char_code == CH_OPEN)) begin
          if ((prev_nxt == PREV_CONST) || (prev_nxt == PREV_VAR) ||
              (prev_nxt == PREV_CLOSE)) begin
            bnd.slots[bnd.count] = '{kind: KIND_OP, symbol: CH_STAR};
            bnd.count = bnd.count + 2'd1;
            prev_nxt  = PREV_OP;
          end
          if (is_digit) begin
            in_num_nxt = 1'b1;
            val_nxt    = {{(MANT_W-4){1'b0}}, in_char_code[3:0]};
            dcnt_nxt   = CNT_W'(1);
            fcnt_nxt   = '0;
            pt_nxt     = 1'b0;
            pt2_nxt    = 1'b0;
          end else if (is_alpha) begin
            bnd.slots[bnd.count] = '{kind: KIND_VAR, symbol: in_char_code};
            bnd.count = bnd.count + 2'd1;
            prev_nxt  = PREV_VAR;
          end else begin
            bnd.slots[bnd.count] = '{kind: KIND_OP, symbol: in_char_code};
            bnd.count = bnd.count + 2'd1;
            prev_nxt  = PREV_OP;
          end
        end else if (is_oper) begin
          bnd.slots[bnd.count] = '{kind: KIND_OP, symbol: in_char_code};
          bnd.count = bnd.count + 2'd1;
          prev_nxt  = (in_char_code == CH_CLOSE) ? PREV_CLOSE : PREV_OP;
        end else begin
          bnd.slots[bnd.count] = '{kind: KIND_ERR, symbol: 8'd0};
          bnd.count = bnd.count + 2'd1;
          err       = 1'b1;
        end
      end

      if (!err && in_is_last && in_num_nxt) begin
        if (!pt2_nxt && (dcnt_nxt <= MAX_D)) begin
          bnd.slots[bnd.count] = '{kind: KIND_CONST, symbol: 8'd0};
          bnd.mantissa = val_nxt;
          bnd.frac     = fcnt_nxt;
        end else begin
          bnd.slots[bnd.count] = '{kind: KIND_ERR, symbol: 8'd0};
          err = 1'b1;
        end
        bnd.count = bnd.count + 2'd1;
      end

      if (err || in_is_last) begin
        if (!err && (bnd.count == 2'd0)) begin
          bnd.slots[0] = '{kind: KIND_END, symbol: 8'd0};
          bnd.count    = 2'd1;
        end
        bnd.eoe    = 1'b1;
        in_num_nxt = 1'b0;
        val_nxt    = '0;
        dcnt_nxt   = '0;
        fcnt_nxt   = '0;
        pt_nxt     = 1'b0;
        pt2_nxt    = 1'b0;
        prev_nxt   = PREV_NONE;
        disc_nxt   = err && !in_is_last;
      end
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && (bnd.count != 2'd0);
  assign q_data   = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_num_r <= 1'b0;
      val_r    <= '0;
      dcnt_r   <= '0;
      fcnt_r   <= '0;
      pt_r     <= 1'b0;
      pt2_r    <= 1'b0;
      prev_r   <= PREV_NONE;
      disc_r   <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_num_r <= in_num_nxt;
      val_r    <= val_nxt;
      dcnt_r   <= dcnt_nxt;
      fcnt_r   <= fcnt_nxt;
      pt_r     <= pt_nxt;
      pt2_r    <= pt2_nxt;
      prev_r   <= prev_nxt;
      disc_r   <= disc_nxt;
    end
  end

  `ELEXM_ASSERT(a_front_disc_idle, disc_r, !in_num_r && (prev_r == PREV_NONE), "discarding with a pending token")
  `ELEXM_ASSERT(a_front_digits, in_num_r, (dcnt_r != '0) && (dcnt_r <= MAX_D1), "digit count out of range")

endmodule

// File: rtl/elexm_queue.sv
`include "expression_lexer_implicit_mul_unit_defines.svh"

module elexm_queue import elexm_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output bundle_t pop_data,
  output logic    empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_QW-1:0] DEPTH_C  = CNT_QW'(QUEUE_DEPTH);

  bundle_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0]   cnt_r;

  assign full     = (cnt_r == DEPTH_C);
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_QW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_QW'(1);
      end
    end
  end

  `ELEXM_ASSERT(a_q_no_overflow, push, !full, "push into a full queue")
  `ELEXM_ASSERT(a_q_no_underflow, pop, !empty, "pop from an empty queue")
  `ELEXM_ASSERT_NEXT(a_q_grow, push && !pop, cnt_r != '0, "queue lost a pushed request")

endmodule

// File: rtl/elexm_back.sv
`include "expression_lexer_implicit_mul_unit_defines.svh"

module elexm_back import elexm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  bundle_t           q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_token_kind,
  output logic [7:0]        out_symbol,
  output logic [MANT_W-1:0] out_mantissa,
  output logic [FRAC_W-1:0] out_fraction_digits,
  output logic              out_last_of_run,
  output logic              out_end_of_expression
);

  logic       valid_r;
  bundle_t    cur_r;
  logic [1:0] idx_r;
  slot_t      slot;
  logic       lor, advance, load;

  assign slot    = cur_r.slots[idx_r];
  assign lor     = (idx_r == (cur_r.count - 2'd1));
  assign advance = valid_r && out_ready;
  assign load    = !q_empty && (!valid_r || (advance && lor));
  assign q_pop   = load;

  assign out_valid             = valid_r;
  assign out_token_kind        = 3'(slot.kind);
  assign out_symbol            = slot.symbol;
  assign out_mantissa          = (slot.kind == KIND_CONST) ? cur_r.mantissa : '0;
  assign out_fraction_digits   = (slot.kind == KIND_CONST) ? cur_r.frac : '0;
  assign out_last_of_run       = lor;
  assign out_end_of_expression = lor && cur_r.eoe;

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (advance) begin
      if (lor) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  `ELEXM_ASSERT(a_back_count, valid_r, (cur_r.count != 2'd0) && (idx_r < cur_r.count), "result index outside the request")
  `ELEXM_ASSERT(a_back_eoe_last, valid_r && cur_r.eoe && !lor, !out_end_of_expression, "expression closed before the last result")

endmodule
